[rtl/sit_pkg.sv]
package sit_pkg;

   localparam int VALUE_W       = 32;
   localparam int STATUS_W      = 3;
   localparam int ENTRY_W       = 7;
   localparam int CAPACITY_DEF  = 64;

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_DELETE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED  = 3'd0,
      ST_FULL      = 3'd1,
      ST_DELETED   = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_EMPTY     = 3'd4
   } sit_status_type;

   typedef enum logic {
      SIT_IDLE   = 1'b0,
      SIT_UPDATE = 1'b1
   } sit_state_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic load_flags;
      logic shift_ins;
      logic shift_del;
   } sit_cell_ctrl_type;

endpackage

[rtl/sorted_integer_table.sv]
// channel   direction  ports                                    handshake
// req       in         req_action, req_value                    req_valid / req_stall
// rsp       out        rsp_status, rsp_entry_count              rsp_valid / rsp_stall
//
// per item, the accept edge loads compare flags into every cell, then the
// update state shifts the cell chain and loads the response register.
// one item at a time; req_stall is high throughout the update state.
// a stalled response holds the update state until the output register is free.
// synchronous reset empties the table; cell contents are not cleared.
module sorted_integer_table #(
   parameter int CAPACITY = sit_pkg::CAPACITY_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_action,
   input  logic signed [sit_pkg::VALUE_W-1:0] req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [sit_pkg::STATUS_W-1:0]       rsp_status,
   output logic [sit_pkg::ENTRY_W-1:0]        rsp_entry_count
);
   import sit_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   sit_state_type             state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic                      op_ff;
   logic signed [VALUE_W-1:0] val_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   sit_status_type            status_ff, status_in;
   logic [ENTRY_W-1:0]        entry_ff, entry_in;

   logic                      accept, out_free, do_update;
   logic                      full, empty, found, do_ins, do_del;
   sit_cell_ctrl_type         ctrl;

   logic signed [VALUE_W-1:0] cell_value [CAPACITY];
   logic [CAPACITY-1:0]       less_vec;
   logic [CAPACITY-1:0]       hit_vec;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign full     = count_ff >= CNT_W'(CAPACITY);
   assign empty    = count_ff == '0;
   assign found    = |hit_vec;
   assign do_ins   = (op_ff == ACT_INSERT) && !full;
   assign do_del   = (op_ff == ACT_DELETE) && !empty && found;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SIT_IDLE:   if (accept) state_in = SIT_UPDATE;
         SIT_UPDATE: if (out_free) state_in = SIT_IDLE;
         default:    state_in = SIT_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall = 1'b0;
      do_update = 1'b0;
      case (state_ff)
         SIT_IDLE:   req_stall = 1'b0;
         SIT_UPDATE: begin
            req_stall = 1'b1;
            do_update = out_free;
         end
         default:    req_stall = 1'b1;
      endcase
   end

   assign ctrl.load_flags = accept;
   assign ctrl.shift_ins  = do_update && do_ins;
   assign ctrl.shift_del  = do_update && do_del;

   always_comb begin
      count_in = count_ff;
      if (ctrl.shift_ins) count_in = count_ff + 1'b1;
      else if (ctrl.shift_del) count_in = count_ff - 1'b1;
   end

   always_comb begin
      if (op_ff == ACT_INSERT) status_in = full ? ST_FULL : ST_INSERTED;
      else if (empty) status_in = ST_EMPTY;
      else status_in = found ? ST_DELETED : ST_NOT_FOUND;
      entry_in = ENTRY_W'(count_in);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (do_update) rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SIT_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_action;
         val_ff <= req_value;
      end
      if (do_update) begin
         status_ff <= status_in;
         entry_ff  <= entry_in;
      end
   end

   genvar i;
   generate
      for (i = 0; i < CAPACITY; i++) begin : g_cell
         logic                      p_less;
         logic signed [VALUE_W-1:0] p_value;
         logic signed [VALUE_W-1:0] n_value;

         if (i == 0) begin : g_first
            assign p_less  = 1'b1;
            assign p_value = val_ff;
         end else begin : g_mid
            assign p_less  = less_vec[i-1];
            assign p_value = cell_value[i-1];
         end

         if (i == CAPACITY - 1) begin : g_last
            assign n_value = cell_value[i];
         end else begin : g_inner
            assign n_value = cell_value[i+1];
         end

         sit_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctrl       (ctrl),
            .count      (count_ff),
            .cmp_value  (req_value),
            .ins_value  (val_ff),
            .prev_less  (p_less),
            .prev_value (p_value),
            .next_value (n_value),
            .value      (cell_value[i]),
            .less       (less_vec[i]),
            .hit        (hit_vec[i])
         );
      end
   endgenerate

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_entry_count = entry_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ff == $past(count_ff) ||
                         count_ff == $past(count_ff) + 1'b1 ||
                         count_ff == $past(count_ff) - 1'b1))
      else $error("entry count moved by more than one");

   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      state_ff == SIT_UPDATE |-> $onehot0(hit_vec))
      else $error("more than one delete position");

   a_accept_update: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == SIT_UPDATE)
      else $error("accepted item did not enter update");

   a_update_rsp: assert property (@(posedge clock) disable iff (reset)
      do_update |=> rsp_valid_ff)
      else $error("update gave no response");

endmodule

[rtl/sit_cell.sv]
module sit_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 7
) (
   input  logic                              clock,
   input  logic                              reset,
   input  sit_pkg::sit_cell_ctrl_type        ctrl,
   input  logic [CNT_W-1:0]                  count,
   input  logic signed [sit_pkg::VALUE_W-1:0] cmp_value,
   input  logic signed [sit_pkg::VALUE_W-1:0] ins_value,
   input  logic                              prev_less,
   input  logic signed [sit_pkg::VALUE_W-1:0] prev_value,
   input  logic signed [sit_pkg::VALUE_W-1:0] next_value,
   output logic signed [sit_pkg::VALUE_W-1:0] value,
   output logic                              less,
   output logic                              hit
);
   import sit_pkg::*;

   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic                      less_ff, less_in;
   logic                      eq_ff, eq_in;
   logic                      occupied;

   assign occupied = CNT_W'(INDEX) < count;

   always_comb begin
      less_in = less_ff;
      eq_in   = eq_ff;
      if (ctrl.load_flags) begin
         less_in = occupied && (value_ff < cmp_value);
         eq_in   = occupied && (value_ff == cmp_value);
      end
   end

   // entries below the insert or delete point keep their place, the rest move one step
   always_comb begin
      value_in = value_ff;
      if (ctrl.shift_ins && !less_ff) begin
         value_in = prev_less ? ins_value : prev_value;
      end else if (ctrl.shift_del && !less_ff) begin
         value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         less_ff <= 1'b0;
         eq_ff   <= 1'b0;
      end else begin
         less_ff <= less_in;
         eq_ff   <= eq_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
   assign less  = less_ff;
   assign hit   = eq_ff && !less_ff && prev_less;

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
   import sit_pkg::*;

   localparam int TABLE_DEPTH = CAPACITY_DEF;
   localparam int CYCLE_LIMIT = 500000;

   localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

   typedef struct {
      sit_status_type       status;
      logic [ENTRY_W-1:0]   count;
   } table_result_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic                        req_action = ACT_INSERT;
   logic signed [VALUE_W-1:0]   req_value = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [STATUS_W-1:0]         rsp_status;
   logic [ENTRY_W-1:0]          rsp_entry_count;

   // ascending copy of what the table should hold
   logic signed [VALUE_W-1:0]   shadow_entries[$];
   table_result_type            awaited_results[$];
   int                          fail_count = 0;
   int                          cycle_count = 0;

   int                          hold_ask = 0;
   int                          hold_left = 0;
   logic [5:0]                  rx_phase = '0;
   logic [7:0]                  rx_mask = '0;
   int                          rx_mode = 0;

   sorted_integer_table #(
      .CAPACITY(TABLE_DEPTH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_entry_count(rsp_entry_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // apply one operation to the shadow table and return the status and count
   function automatic table_result_type shadow_update(logic act, logic signed [VALUE_W-1:0] v);
      int               pos;
      table_result_type r;
      pos = 0;
      if (act == ACT_INSERT) begin
         if (shadow_entries.size() >= TABLE_DEPTH) begin
            r.status = ST_FULL;
         end else begin
            while (pos < shadow_entries.size() && shadow_entries[pos] < v)
               pos++;
            shadow_entries.insert(pos, v);
            r.status = ST_INSERTED;
         end
      end else if (shadow_entries.size() == 0) begin
         r.status = ST_EMPTY;
      end else begin
         while (pos < shadow_entries.size() && shadow_entries[pos] != v)
            pos++;
         if (pos >= shadow_entries.size()) begin
            r.status = ST_NOT_FOUND;
         end else begin
            shadow_entries.delete(pos);
            r.status = ST_DELETED;
         end
      end
      r.count = ENTRY_W'(shadow_entries.size());
      return r;
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_value(logic act);
      int sel;
      sel = $urandom_range(0, 99);
      if (act == ACT_DELETE && shadow_entries.size() > 0 && sel < 55)
         return shadow_entries[$urandom_range(0, shadow_entries.size() - 1)];
      if (sel < 35)
         return $signed(32'($urandom_range(0, 16))) - 8;
      if (sel < 45) begin
         case ($urandom_range(0, 3))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return '0;
            default: return -1;
         endcase
      end
      return $urandom;
   endfunction

   // result checker
   always @(posedge clock) begin
      table_result_type exp;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (awaited_results.size() == 0) begin
            fail_count++;
            $display("%0t: result with nothing expected: status %0d count %0d",
                     $realtime, rsp_status, rsp_entry_count);
         end else begin
            exp = awaited_results.pop_front();
            if (rsp_status !== exp.status) begin
               fail_count++;
               $display("%0t: status expected %0d actual %0d",
                        $realtime, exp.status, rsp_status);
            end
            if (rsp_entry_count !== exp.count) begin
               fail_count++;
               $display("%0t: entry_count expected %0d actual %0d",
                        $realtime, exp.count, rsp_entry_count);
            end
         end
      end
   end

   // receiver: stall pattern changes each time the 6-bit phase counter wraps, long hold-off on request
   always @(posedge clock) begin
      rx_phase <= rx_phase + 1'b1;
      if (hold_ask != 0) begin
         hold_left <= hold_ask;
         hold_ask = 0;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         if (rx_phase == 0) begin
            rx_mask <= $urandom;
            rx_mode <= $urandom_range(0, 3);
         end
         case (rx_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= rx_mask[rx_phase[2:0]];
            2: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 4) != 0);
         endcase
      end
   end

   task automatic send_item(input logic act, input logic signed [VALUE_W-1:0] v);
      req_valid  <= 1'b1;
      req_action <= act;
      req_value  <= v;
      do @(posedge clock); while (req_stall !== 1'b0);
      awaited_results.push_back(shadow_update(act, v));
   endtask

   task automatic idle_sender(input int cycles);
      if (cycles > 0) begin
         req_valid  <= 1'b0;
         req_action <= 1'($urandom);
         req_value  <= $urandom;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (awaited_results.size() != 0)
         @(posedge clock);
   endtask

   // request is handed over between edges, then the sender is back on the rising edge
   task automatic hold_receiver(input int cycles);
      @(negedge clock);
      hold_ask = cycles;
      @(posedge clock);
   endtask

   task automatic test_directed();
      send_item(ACT_DELETE, 5);          // empty table
      send_item(ACT_INSERT, 0);
      send_item(ACT_INSERT, 0);          // duplicate goes first
      send_item(ACT_INSERT, VAL_MAX);
      send_item(ACT_INSERT, VAL_MIN);
      send_item(ACT_INSERT, -1);
      send_item(ACT_INSERT, 1);
      send_item(ACT_INSERT, 0);
      send_item(ACT_DELETE, 7);          // absent
      send_item(ACT_DELETE, 0);          // one copy only
      send_item(ACT_DELETE, VAL_MIN);
      send_item(ACT_DELETE, VAL_MAX);
      send_item(ACT_INSERT, VAL_MIN);
      send_item(ACT_INSERT, VAL_MAX);
      send_item(ACT_DELETE, -1);
      send_item(ACT_DELETE, 0);
      send_item(ACT_DELETE, 0);
      send_item(ACT_DELETE, 0);          // zeros already gone, not found
      send_item(ACT_DELETE, 1);
      send_item(ACT_DELETE, VAL_MAX);
      send_item(ACT_DELETE, VAL_MIN);
      send_item(ACT_DELETE, VAL_MIN);    // empty again
      wait_for_results();
   endtask

   task automatic test_fill_and_empty();
      while (shadow_entries.size() < TABLE_DEPTH) begin
         send_item(ACT_INSERT, pick_value(ACT_INSERT));
         if ($urandom_range(0, 5) == 0)
            idle_sender($urandom_range(1, 4));
      end
      repeat (3) send_item(ACT_INSERT, pick_value(ACT_INSERT));
      while (shadow_entries.size() > 0) begin
         if ($urandom_range(0, 7) == 0)
            send_item(ACT_DELETE, $urandom);
         else
            send_item(ACT_DELETE, shadow_entries[$urandom_range(0, shadow_entries.size() - 1)]);
      end
      send_item(ACT_DELETE, pick_value(ACT_DELETE));
      wait_for_results();
   endtask

   task automatic test_backpressure();
      hold_receiver(60);
      repeat (14) begin
         if ($urandom_range(0, 1) == 0)
            send_item(ACT_INSERT, pick_value(ACT_INSERT));
         else
            send_item(ACT_DELETE, pick_value(ACT_DELETE));
      end
      wait_for_results();
   endtask

   task automatic test_random_traffic(input int n_items);
      int  sent;
      int  burst;
      int  insert_pct;
      logic act;
      sent = 0;
      insert_pct = 60;
      while (sent < n_items) begin
         burst = $urandom_range(1, 24);
         // drift the mix so the table swings between empty and full
         if ($urandom_range(0, 3) == 0)
            insert_pct = $urandom_range(20, 85);
         repeat (burst) begin
            act = ($urandom_range(0, 99) < insert_pct) ? ACT_INSERT : ACT_DELETE;
            send_item(act, pick_value(act));
            sent++;
         end
         if ($urandom_range(0, 2) == 0)
            idle_sender(0);
         else
            idle_sender($urandom_range(1, 8));
      end
      wait_for_results();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_fill_and_empty();
      test_random_traffic(600);
      test_backpressure();
      test_random_traffic(700);
      test_fill_and_empty();
      test_backpressure();
      test_random_traffic(700);
      wait_for_results();
      repeat (16) @(posedge clock);
      if (fail_count == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule
